@@ hdl/srrw_pkg.sv @@
// Package for the selective-repeat receive window unit.
// Holds the sizing constants, result codes and the queued command type.
// No dependencies.
package srrw_pkg;

  // Sequence space, receive window and payload sizing
  localparam int SEQ_SPACE    = 8;
  localparam int WINDOW_DEPTH = 4;
  localparam int PAYLOAD_BITS = 64;

  // Fixed port field widths
  localparam int SEQ_FIELD_W     = 3;
  localparam int PAYLOAD_FIELD_W = 64;

  // Derived widths
  localparam int SEQ_IDX_W  = (SEQ_SPACE > 1) ? $clog2(SEQ_SPACE) : 1;
  localparam int RUN_LIMIT  = (WINDOW_DEPTH < SEQ_SPACE) ? WINDOW_DEPTH : SEQ_SPACE;
  localparam int RUN_CNT_W  = $clog2(RUN_LIMIT + 1);

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Result kinds
  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  // Classified packet, handed from front to back
  typedef struct packed {
    logic                    in_range;
    logic [SEQ_IDX_W-1:0]    seq;
    logic [PAYLOAD_BITS-1:0] payload;
  } srrw_cmd_t;

endpackage

@@ hdl/srrw_front.sv @@
// Front end of the receive window unit: accepts packets, drops bad ones.
// Good packets are classified by sequence range and pushed to the queue.
// Depends on srrw_pkg.
module srrw_front import srrw_pkg::*; (
  input  logic                       pkt_valid,
  output logic                       pkt_ready,
  input  logic [SEQ_FIELD_W-1:0]     seq_num,
  input  logic [PAYLOAD_FIELD_W-1:0] payload_word,
  input  logic                       checksum_ok,
  output logic                       push_valid,
  input  logic                       push_ready,
  output srrw_cmd_t                  push_cmd
);

  // Take a packet whenever the queue has room
  assign pkt_ready = push_ready;

  // Drop packets with a bad checksum; they leave no trace
  assign push_valid = pkt_valid && checksum_ok;

  // Classify: sequence numbers past the sequence space never match the window
  always_comb begin
    push_cmd.in_range = (int'(seq_num) < SEQ_SPACE);
    push_cmd.seq      = SEQ_IDX_W'(seq_num);
    push_cmd.payload  = payload_word[PAYLOAD_BITS-1:0];
  end

endmodule

@@ hdl/srrw_queue.sv @@
// Short command queue between the front and back of the window unit.
// Lets packet intake and result delivery stall independently.
// Depends on srrw_pkg.
module srrw_queue import srrw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  output logic      push_ready,
  input  srrw_cmd_t push_cmd,
  output logic      pop_valid,
  input  logic      pop_ready,
  output srrw_cmd_t pop_cmd
);

  srrw_cmd_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr;
  logic [QPTR_W-1:0]     rd_ptr;
  logic [QCNT_W-1:0]     count;
  logic                  do_push;
  logic                  do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

@@ hdl/srrw_back.sv @@
// Back end of the window unit: window check, payload store, in-order delivery.
// Owns the window base, held flags, payload store and the output register.
// Depends on srrw_pkg.
module srrw_back import srrw_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       pop_valid,
  output logic                       pop_ready,
  input  srrw_cmd_t                  pop_cmd,
  output logic                       res_valid,
  input  logic                       res_ready,
  output logic                       kind,
  output logic [PAYLOAD_FIELD_W-1:0] delivered_payload,
  output logic [SEQ_FIELD_W-1:0]     ack_number,
  output logic                       last
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_ACK  = 3'b100
  } state_t;

  state_t                  state;
  logic [SEQ_IDX_W-1:0]    base;
  logic [SEQ_IDX_W-1:0]    base_inc;
  logic [SEQ_SPACE-1:0]    held;
  logic [PAYLOAD_BITS-1:0] store [SEQ_SPACE];
  logic [RUN_CNT_W-1:0]    run_cnt;
  logic [SEQ_IDX_W:0]      seq_gap;
  logic                    in_win;
  logic                    take;
  logic                    keep;
  logic                    slot_free;
  logic                    run_go;
  logic                    emit_deliver;
  logic                    emit_ack;

  // Window distance of the queued sequence number from the base
  always_comb begin
    if (pop_cmd.seq >= base) begin
      seq_gap = {1'b0, pop_cmd.seq} - {1'b0, base};
    end else begin
      seq_gap = {1'b0, pop_cmd.seq} + (SEQ_IDX_W + 1)'(SEQ_SPACE) - {1'b0, base};
    end
    in_win = (int'(seq_gap) < WINDOW_DEPTH);
  end

  // Take a command only when idle; keep it if new and inside the window
  assign pop_ready = (state == S_IDLE);
  assign take      = pop_valid && pop_ready;
  assign keep      = take && pop_cmd.in_range && in_win && !held[pop_cmd.seq];

  // Delivery run control
  assign base_inc     = (base == SEQ_IDX_W'(SEQ_SPACE - 1)) ? '0 : base + 1'b1;
  assign slot_free    = !res_valid || res_ready;
  assign run_go       = held[base] && (run_cnt < RUN_CNT_W'(RUN_LIMIT));
  assign emit_deliver = (state == S_RUN) && slot_free && run_go;
  assign emit_ack     = slot_free && (((state == S_RUN) && !run_go) || (state == S_ACK));

  // Sequencer, window base and held flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      base      <= '0;
      held      <= '0;
      run_cnt   <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      if (emit_deliver || emit_ack) begin
        res_valid <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            run_cnt <= '0;
            if (keep) begin
              held[pop_cmd.seq] <= 1'b1;
            end
            state <= (keep && (pop_cmd.seq == base)) ? S_RUN : S_ACK;
          end
        end
        S_RUN: begin
          if (emit_deliver) begin
            held[base] <= 1'b0;
            base       <= base_inc;
            run_cnt    <= run_cnt + 1'b1;
          end else if (emit_ack) begin
            state <= S_IDLE;
          end
        end
        S_ACK: begin
          if (emit_ack) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Write kept payloads
  always_ff @(posedge clk) begin
    if (keep) begin
      store[pop_cmd.seq] <= pop_cmd.payload;
    end
  end

  // Load the output register; deliveries carry the advanced base
  always_ff @(posedge clk) begin
    if (emit_deliver) begin
      kind              <= KIND_DELIVER;
      delivered_payload <= PAYLOAD_FIELD_W'(store[base]);
      ack_number        <= SEQ_FIELD_W'(base_inc);
      last              <= 1'b0;
    end else if (emit_ack) begin
      kind              <= KIND_ACK;
      delivered_payload <= '0;
      ack_number        <= SEQ_FIELD_W'(base);
      last              <= 1'b1;
    end
  end

endmodule

@@ hdl/selective_repeat_receive_window_unit.sv @@
// Selective-repeat ARQ receiver window, top level.
// Instantiates srrw_front, srrw_queue and srrw_back; depends on srrw_pkg.
//
// Usage:
//   Packet channel (pkt_valid/pkt_ready) carries seq_num, payload_word and
//   checksum_ok. Result channel (res_valid/res_ready) carries kind,
//   delivered_payload, ack_number and last.
//   A packet with a bad checksum is dropped with no result. Every good packet
//   gives zero or more in-order deliveries (kind 0) followed by one
//   acknowledgement (kind 1, last 1) holding the next expected number.
//   Flow: a good packet is written into the two-entry command queue; the back
//   end pops it and checks the window when idle, then loads one result per
//   cycle while the output register is free: n words (n at most 4), then the
//   acknowledgement. The back end takes one packet at a time and takes no
//   new one from the queue until its acknowledgement is loaded.
//   Packets keep being accepted while the queue has room, including while a
//   result waits in the output register.
//   When res_ready is low, the output register holds its transfer, the back
//   end stalls, and the queue fills and then drops pkt_ready.
//   Reset (rst, synchronous) clears the window base to zero, clears all held
//   flags and empties the queue; no clearing pass is needed.
module selective_repeat_receive_window_unit import srrw_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       pkt_valid,
  output logic                       pkt_ready,
  input  logic [SEQ_FIELD_W-1:0]     seq_num,
  input  logic [PAYLOAD_FIELD_W-1:0] payload_word,
  input  logic                       checksum_ok,
  output logic                       res_valid,
  input  logic                       res_ready,
  output logic                       kind,
  output logic [PAYLOAD_FIELD_W-1:0] delivered_payload,
  output logic [SEQ_FIELD_W-1:0]     ack_number,
  output logic                       last
);

  logic      push_valid;
  logic      push_ready;
  srrw_cmd_t push_cmd;
  logic      pop_valid;
  logic      pop_ready;
  srrw_cmd_t pop_cmd;

  // Accept and classify packets
  srrw_front u_front (
    .pkt_valid    (pkt_valid),
    .pkt_ready    (pkt_ready),
    .seq_num      (seq_num),
    .payload_word (payload_word),
    .checksum_ok  (checksum_ok),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_cmd     (push_cmd)
  );

  // Decouple intake from delivery
  srrw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // Window update and in-order delivery
  srrw_back u_back (
    .clk               (clk),
    .rst               (rst),
    .pop_valid         (pop_valid),
    .pop_ready         (pop_ready),
    .pop_cmd           (pop_cmd),
    .res_valid         (res_valid),
    .res_ready         (res_ready),
    .kind              (kind),
    .delivered_payload (delivered_payload),
    .ack_number        (ack_number),
    .last              (last)
  );

endmodule
